>>> rtl/jhse_pkg.sv
// ----------------------------------------------------------------------------
// jhse_pkg
// Shared types, action codes and Huffman code ROMs for the JPEG Huffman
// encoder with byte stuffing. The canonical codes are built at elaboration
// from the standard length counts and value lists.
// ----------------------------------------------------------------------------
package jhse_pkg;

  localparam int JHSE_QUEUE_DEPTH = 4;

  localparam logic [1:0] ACT_ENCODE = 2'd0;
  localparam logic [1:0] ACT_FLUSH  = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  localparam logic [7:0] STUFF_MARK = 8'hff;
  localparam logic [7:0] STUFF_ZERO = 8'h00;
  localparam logic [3:0] FULL_COUNT = 4'd8;

  localparam int ENTRY_W = 21;
  localparam int ROM_W   = 256 * ENTRY_W;

  typedef logic [16*8-1:0]  lens_t;
  typedef logic [162*8-1:0] vals_t;
  typedef logic [ROM_W-1:0] rom_t;

  typedef struct packed {
    logic [4:0]  len;
    logic [15:0] code;
  } entry_t;

  typedef struct packed {
    logic [7:0] data0;
    logic [7:0] data1;
    logic [3:0] count;
    logic       pair;
  } job_t;

  // Length counts for code lengths 1..16, first length in the top byte.
  localparam lens_t DC_LUMA_LENS = {
    8'd0, 8'd1, 8'd5, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };
  localparam lens_t DC_CHROMA_LENS = {
    8'd0, 8'd3, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
    8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };
  localparam lens_t AC_LUMA_LENS = {
    8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
    8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'h7d
  };
  localparam lens_t AC_CHROMA_LENS = {
    8'd0, 8'd2, 8'd1, 8'd2, 8'd4, 8'd4, 8'd3, 8'd4,
    8'd7, 8'd5, 8'd4, 8'd4, 8'd0, 8'd1, 8'd2, 8'h77
  };

  // Value lists, first value in the top byte.
  localparam vals_t AC_LUMA_VALS = {
    8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12, 8'h21, 8'h31, 8'h41, 8'h06,
    8'h13, 8'h51, 8'h61, 8'h07, 8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91, 8'ha1, 8'h08,
    8'h23, 8'h42, 8'hb1, 8'hc1, 8'h15, 8'h52, 8'hd1, 8'hf0, 8'h24, 8'h33, 8'h62, 8'h72,
    8'h82, 8'h09, 8'h0a, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h25, 8'h26, 8'h27, 8'h28,
    8'h29, 8'h2a, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h43, 8'h44, 8'h45,
    8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
    8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h73, 8'h74, 8'h75,
    8'h76, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
    8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a, 8'ha2, 8'ha3,
    8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4, 8'hb5, 8'hb6,
    8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7, 8'hc8, 8'hc9,
    8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda, 8'he1, 8'he2,
    8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'hf1, 8'hf2, 8'hf3, 8'hf4,
    8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa
  };
  localparam vals_t AC_CHROMA_VALS = {
    8'h00, 8'h01, 8'h02, 8'h03, 8'h11, 8'h04, 8'h05, 8'h21, 8'h31, 8'h06, 8'h12, 8'h41,
    8'h51, 8'h07, 8'h61, 8'h71, 8'h13, 8'h22, 8'h32, 8'h81, 8'h08, 8'h14, 8'h42, 8'h91,
    8'ha1, 8'hb1, 8'hc1, 8'h09, 8'h23, 8'h33, 8'h52, 8'hf0, 8'h15, 8'h62, 8'h72, 8'hd1,
    8'h0a, 8'h16, 8'h24, 8'h34, 8'he1, 8'h25, 8'hf1, 8'h17, 8'h18, 8'h19, 8'h1a, 8'h26,
    8'h27, 8'h28, 8'h29, 8'h2a, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3a, 8'h43, 8'h44,
    8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
    8'h59, 8'h5a, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h73, 8'h74,
    8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87,
    8'h88, 8'h89, 8'h8a, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
    8'ha2, 8'ha3, 8'ha4, 8'ha5, 8'ha6, 8'ha7, 8'ha8, 8'ha9, 8'haa, 8'hb2, 8'hb3, 8'hb4,
    8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7,
    8'hc8, 8'hc9, 8'hca, 8'hd2, 8'hd3, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8, 8'hd9, 8'hda,
    8'he2, 8'he3, 8'he4, 8'he5, 8'he6, 8'he7, 8'he8, 8'he9, 8'hea, 8'hf2, 8'hf3, 8'hf4,
    8'hf5, 8'hf6, 8'hf7, 8'hf8, 8'hf9, 8'hfa
  };

  // Build a symbol-indexed ROM of {length, code}; length zero marks absent.
  function automatic rom_t build_rom(lens_t lens, vals_t vals, int nvals, logic ident);
    rom_t        rom;
    logic [15:0] code;
    int          k;
    int          n;
    int          sym;
    rom  = '0;
    code = '0;
    k    = 0;
    for (int len = 1; len <= 16; len++) begin
      n = int'(lens[(16 - len)*8 +: 8]);
      for (int j = 0; j < n; j++) begin
        if (k < nvals) begin
          sym = ident ? k : int'(vals[(161 - k)*8 +: 8]);
          if (rom[sym*ENTRY_W + 16 +: 5] == 5'd0) begin
            rom[sym*ENTRY_W +: ENTRY_W] = {5'(len), code};
          end
          code = code + 16'd1;
          k    = k + 1;
        end
      end
      code = code << 1;
    end
    return rom;
  endfunction

  localparam rom_t DC_LUMA_ROM   = build_rom(DC_LUMA_LENS, AC_LUMA_VALS, 12, 1'b1);
  localparam rom_t DC_CHROMA_ROM = build_rom(DC_CHROMA_LENS, AC_LUMA_VALS, 12, 1'b1);
  localparam rom_t AC_LUMA_ROM   = build_rom(AC_LUMA_LENS, AC_LUMA_VALS, 162, 1'b0);
  localparam rom_t AC_CHROMA_ROM = build_rom(AC_CHROMA_LENS, AC_CHROMA_VALS, 162, 1'b0);

  function automatic entry_t rom_read(rom_t rom, logic [7:0] sym);
    return entry_t'(rom[int'(sym)*ENTRY_W +: ENTRY_W]);
  endfunction

endpackage

>>> rtl/jhse_front.sv
// ----------------------------------------------------------------------------
// jhse_front
// Accepts requests, looks up the Huffman code, packs it behind the pending
// bits and hands whole bytes or flush residue to the queue as one job.
// ----------------------------------------------------------------------------
module jhse_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  input  logic [7:0]        symbol,
  input  logic              is_dc,
  input  logic [1:0]        component,
  output logic              push,
  output jhse_pkg::job_t    push_job,
  input  logic              push_ready
);
  import jhse_pkg::*;

  logic [6:0]  pend;
  logic [2:0]  pcount;
  logic [6:0]  pend_next;
  logic [2:0]  pcount_next;
  entry_t      ent;
  logic        hit;
  logic [22:0] acc;
  logic [4:0]  cnt;
  logic        want;

  assign in_ready = push_ready;

  always_comb begin
    if (is_dc) begin
      ent = (component == 2'd0) ? rom_read(DC_LUMA_ROM, symbol)
                                : rom_read(DC_CHROMA_ROM, symbol);
    end else begin
      ent = (component == 2'd0) ? rom_read(AC_LUMA_ROM, symbol)
                                : rom_read(AC_CHROMA_ROM, symbol);
    end
    hit = (component != 2'd3) && (ent.len != 5'd0);
    acc = ({16'd0, pend} << ent.len) | {7'd0, ent.code};
    cnt = {2'd0, pcount} + ent.len;

    pend_next      = pend;
    pcount_next    = pcount;
    want           = 1'b0;
    push_job.data0 = 8'(acc >> (cnt - 5'd8));
    push_job.data1 = 8'(acc >> (cnt - 5'd16));
    push_job.count = FULL_COUNT;
    push_job.pair  = cnt[4];

    case (action)
      ACT_ENCODE: begin
        if (hit) begin
          want        = (cnt >= 5'd8);
          pcount_next = cnt[2:0];
          pend_next   = 7'(acc) & 7'((8'd1 << cnt[2:0]) - 8'd1);
        end
      end
      ACT_FLUSH: begin
        want           = (pcount != 3'd0);
        push_job.data0 = {1'b0, pend};
        push_job.count = {1'b0, pcount};
        push_job.pair  = 1'b0;
        pend_next      = '0;
        pcount_next    = '0;
      end
      ACT_CLEAR: begin
        pend_next   = '0;
        pcount_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign push = in_valid && want;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend   <= '0;
      pcount <= '0;
    end else if (in_valid && in_ready) begin
      pend   <= pend_next;
      pcount <= pcount_next;
    end
  end

  a_pend_masked: assert property (@(posedge clk) disable iff (rst)
    (8'({1'b0, pend} >> pcount) == 8'd0))
    else $error("pending bits above pending count");

endmodule

>>> rtl/jhse_queue.sv
// ----------------------------------------------------------------------------
// jhse_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module jhse_queue #(
  parameter int DEPTH = jhse_pkg::JHSE_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  jhse_pkg::job_t    wr_job,
  output logic              rd_valid,
  input  logic              rd_pop,
  output jhse_pkg::job_t    rd_job
);
  import jhse_pkg::*;

  localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] used;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (used != CW'(DEPTH));
  assign rd_valid = (used != '0);
  assign rd_job   = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        used <= used + 1'b1;
      end else if (do_rd && !do_wr) begin
        used <= used - 1'b1;
      end
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(DEPTH))
    else $error("queue overfilled");

endmodule

>>> rtl/jhse_back.sv
// ----------------------------------------------------------------------------
// jhse_back
// Walks each queued job one byte per cycle while the output is not stalled,
// inserts a zero after every marker byte and drives the output register.
// ----------------------------------------------------------------------------
module jhse_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  jhse_pkg::job_t    job,
  output logic              job_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,
  output logic              m_tlast
);
  import jhse_pkg::*;

  logic       sel;
  logic       stuff;
  logic [7:0] cur_data;
  logic [3:0] cur_count;
  logic       cur_mark;
  logic       more;
  logic       load;

  always_comb begin
    cur_data  = stuff ? STUFF_ZERO : (sel ? job.data1 : job.data0);
    cur_count = stuff ? FULL_COUNT : job.count;
    cur_mark  = !stuff && (job.count == FULL_COUNT) && (cur_data == STUFF_MARK);
    more      = cur_mark || (!sel && job.pair);
  end

  assign load    = job_valid && (!m_tvalid || m_tready);
  assign job_pop = load && !more;

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {4'd0, cur_count, cur_data};
      m_tlast <= !more;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      sel      <= 1'b0;
      stuff    <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load) begin
        if (cur_mark) begin
          stuff <= 1'b1;
        end else if (more) begin
          stuff <= 1'b0;
          sel   <= 1'b1;
        end else begin
          stuff <= 1'b0;
          sel   <= 1'b0;
        end
      end
    end
  end

  a_mark_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[7:0] == STUFF_MARK) && (m_tdata[11:8] == FULL_COUNT)
    |-> !m_tlast)
    else $error("marker byte ended a request without its stuffed zero");

  a_stuff_follows: assert property (@(posedge clk) disable iff (rst)
    load && cur_mark |=> stuff && job_valid)
    else $error("stuffed zero lost its job");

  a_phase_holds_job: assert property (@(posedge clk) disable iff (rst)
    (sel || stuff) |-> job_valid)
    else $error("mid-job phase without a queued job");

endmodule

>>> rtl/jpeg_huffman_stuffing_encoder_unit.sv
// ----------------------------------------------------------------------------
// jpeg_huffman_stuffing_encoder_unit
// Baseline JPEG Huffman encoder with 0xFF byte stuffing.
// ----------------------------------------------------------------------------
// Input channel s_*: one request per handshake. s_tdata carries the symbol,
// s_tuser the action (encode, flush, clear), the DC/AC select and the
// component. Output channel m_*: one byte or flush residue per handshake,
// m_tdata holds the bits and their count, m_tlast marks the final result of
// a request.
// A request is accepted every cycle while the job queue has room; the front
// part packs it into a job in that same cycle. The back part emits one
// result per cycle while the receiver is ready, so an encode gives 0 to 4
// results (two data bytes plus a stuffed zero after each 0xFF), a flush 0
// or 1. The back part's one byte per cycle sets the sustained rate.
// The first result is registered in the queue, then in the output register.
// Reset empties the queue, drops the pending bits and clears m_tvalid.
// When the receiver stalls, the output register holds, the queue fills and
// then s_tready drops; no result is lost.
// ----------------------------------------------------------------------------
module jpeg_huffman_stuffing_encoder_unit #(
  parameter int QUEUE_DEPTH = jhse_pkg::JHSE_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // symbol
  input  logic [4:0]  s_tuser,   // action[1:0], is_dc[2], component[4:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_data[7:0], out_count[11:8], zero fill
  output logic        m_tlast    // last
);
  import jhse_pkg::*;

  logic q_wr_valid;
  logic q_wr_ready;
  job_t q_wr_job;
  logic q_rd_valid;
  logic q_rd_pop;
  job_t q_rd_job;

  jhse_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .action     (s_tuser[1:0]),
    .symbol     (s_tdata),
    .is_dc      (s_tuser[2]),
    .component  (s_tuser[4:3]),
    .push       (q_wr_valid),
    .push_job   (q_wr_job),
    .push_ready (q_wr_ready)
  );

  jhse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_job   (q_wr_job),
    .rd_valid (q_rd_valid),
    .rd_pop   (q_rd_pop),
    .rd_job   (q_rd_job)
  );

  jhse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_rd_valid),
    .job       (q_rd_job),
    .job_pop   (q_rd_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule
